@@ hw/rtl/cct_pkg.sv @@
// ----------------------------------------------------------------------------
// cct_pkg: shared types and constants of the compacting client table
// Transaction field widths, stream packing widths, operation kinds and the
// item and result records handed between the stages.
// ----------------------------------------------------------------------------
package cct_pkg;

  localparam int unsigned ENTRIES_DEF = 4;
  localparam int unsigned ID_BITS_DEF = 8;

  localparam int unsigned KIND_W     = 2;
  localparam int unsigned CID_W      = 8;
  localparam int unsigned SECS_W     = 16;
  localparam int unsigned POS_W      = 3;
  localparam int unsigned COUNT_W    = 3;
  localparam int unsigned CHANGES_W  = 32;

  // client_id, interval, preheat, prime, position: 44 bits, kind rides on tuser
  localparam int unsigned S_TDATA_W  = 48;
  // ok, id, interval, preheat, prime, entry_count, change_count: 77 bits
  localparam int unsigned M_TDATA_W  = 80;

  typedef enum logic [KIND_W-1:0] {
    KIND_UPSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_GET    = 2'd2,
    KIND_AT     = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic [CID_W-1:0]    client_id;
    logic [SECS_W-1:0]   interval_seconds;
    logic [SECS_W-1:0]   preheat_seconds;
    logic                prime_flag;
    logic [POS_W-1:0]    position;
  } item_t;

  typedef struct packed {
    logic                 ok;
    logic [CID_W-1:0]     found_id;
    logic [SECS_W-1:0]    found_interval;
    logic [SECS_W-1:0]    found_preheat;
    logic                 found_prime;
    logic [COUNT_W-1:0]   entry_count;
    logic [CHANGES_W-1:0] change_count;
  } result_t;

endpackage

@@ hw/rtl/compacting_client_table.sv @@
// ----------------------------------------------------------------------------
// compacting_client_table: keyed table of client profiles, packed low
// Stream in one operation (upsert, remove, get, read at position) per
// transaction, stream out one result per operation.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries operations, m_axis carries results, one result for every
//   accepted operation and in the same order.
//   An accepted operation is held in the input register, where the table
//   compares all slots at once, then its result and the table update are
//   registered together into the output register that drives m_axis.
//   Throughput is one operation per cycle while m_axis is not stalled, set
//   by the single compare-and-update pass on the slot registers; the next
//   operation sees the table as the previous one left it.
//   When m_axis is stalled the output register holds its result and the
//   input register holds one more operation; s_axis_tready drops only when
//   both are full and m_axis_tready is low.
//   Reset empties the table, clears the entry count and the change counter
//   and drops both pipeline registers. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module compacting_client_table #(
  parameter int unsigned ENTRIES = cct_pkg::ENTRIES_DEF,
  parameter int unsigned ID_BITS = cct_pkg::ID_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // client_id, interval_seconds, preheat_seconds, prime_flag, position
  input  logic [cct_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // kind
  input  logic [cct_pkg::KIND_W-1:0]     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // ok, found_id, found_interval, found_preheat, found_prime, entry_count,
  // change_count
  output logic [cct_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
  import cct_pkg::*;

  item_t   in_item;
  item_t   s1_item_q;
  logic    s1_valid_q;
  logic    out_free;
  logic    s1_adv;
  result_t res;
  result_t out_q;
  logic    out_valid_q;

  always_comb begin
    in_item.kind             = kind_e'(s_axis_tuser);
    in_item.client_id        = s_axis_tdata[7:0];
    in_item.interval_seconds = s_axis_tdata[23:8];
    in_item.preheat_seconds  = s_axis_tdata[39:24];
    in_item.prime_flag       = s_axis_tdata[40];
    in_item.position         = s_axis_tdata[43:41];
  end

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_adv        = s1_valid_q && out_free;
  assign s_axis_tready = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_item_q <= in_item;
    end
  end

  cct_table #(
    .ENTRIES (ENTRIES),
    .ID_BITS (ID_BITS)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (s1_item_q),
    .commit_i (s1_adv),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000,
                          out_q.change_count,
                          out_q.entry_count,
                          out_q.found_prime,
                          out_q.found_preheat,
                          out_q.found_interval,
                          out_q.found_id,
                          out_q.ok};

endmodule

@@ hw/rtl/cct_table.sv @@
// ----------------------------------------------------------------------------
// cct_table: profile storage and single-pass operation logic
// Holds the packed slots, entry count and change counter, works out the
// result of the staged transaction and commits the table update on commit_i.
// ----------------------------------------------------------------------------
module cct_table #(
  parameter int unsigned ENTRIES = cct_pkg::ENTRIES_DEF,
  parameter int unsigned ID_BITS = cct_pkg::ID_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cct_pkg::item_t  item_i,
  input  logic            commit_i,
  output cct_pkg::result_t result_o
);
  import cct_pkg::*;

  localparam int unsigned OCC_W = $clog2(ENTRIES + 1);

  logic [ID_BITS-1:0]   slot_id_q       [ENTRIES];
  logic [SECS_W-1:0]    slot_interval_q [ENTRIES];
  logic [SECS_W-1:0]    slot_preheat_q  [ENTRIES];
  logic                 slot_prime_q    [ENTRIES];
  logic [ID_BITS-1:0]   slot_id_d       [ENTRIES];
  logic [SECS_W-1:0]    slot_interval_d [ENTRIES];
  logic [SECS_W-1:0]    slot_preheat_d  [ENTRIES];
  logic                 slot_prime_d    [ENTRIES];
  logic [OCC_W-1:0]     occ_q, occ_d;
  logic [CHANGES_W-1:0] changes_q, changes_d;

  logic [ID_BITS-1:0]   id_w;
  logic                 id_nz;
  logic [ENTRIES-1:0]   hit_vec;
  logic [ENTRIES-1:0]   at_vec;
  logic [ENTRIES-1:0]   shift_vec;
  logic [ENTRIES-1:0]   rd_vec;
  logic                 any_hit;
  logic                 full;
  logic                 ok;
  logic [ID_BITS-1:0]   rd_id;
  logic [SECS_W-1:0]    rd_interval;
  logic [SECS_W-1:0]    rd_preheat;
  logic                 rd_prime;

  assign id_w    = ID_BITS'(item_i.client_id);
  assign id_nz   = |id_w;
  assign full    = (occ_q == OCC_W'(ENTRIES));

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = id_nz && (int'(occ_q) > i) && (slot_id_q[i] == id_w);
      at_vec[i]  = (int'(occ_q) > i) && (int'(item_i.position) == i);
    end
    // every slot from the removed one upward takes its upper neighbor, the top one is cleared
    shift_vec[0] = hit_vec[0];
    for (int i = 1; i < ENTRIES; i++) begin
      shift_vec[i] = shift_vec[i-1] | hit_vec[i];
    end
  end

  assign any_hit = |hit_vec;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      slot_id_d[i]       = slot_id_q[i];
      slot_interval_d[i] = slot_interval_q[i];
      slot_preheat_d[i]  = slot_preheat_q[i];
      slot_prime_d[i]    = slot_prime_q[i];
    end
    occ_d     = occ_q;
    changes_d = changes_q;
    ok        = 1'b0;
    rd_vec    = '0;

    unique case (item_i.kind)
      KIND_UPSERT: begin
        if (id_nz && (any_hit || !full)) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (any_hit ? hit_vec[i] : (int'(occ_q) == i)) begin
              slot_id_d[i]       = id_w;
              slot_interval_d[i] = item_i.interval_seconds;
              slot_preheat_d[i]  = item_i.preheat_seconds;
              slot_prime_d[i]    = item_i.prime_flag;
            end
          end
          if (!any_hit) begin
            occ_d = occ_q + 1'b1;
          end
          changes_d = changes_q + 1'b1;
          ok        = 1'b1;
        end
      end
      KIND_REMOVE: begin
        if (any_hit) begin
          for (int i = 0; i < ENTRIES - 1; i++) begin
            if (shift_vec[i]) begin
              slot_id_d[i]       = slot_id_q[i+1];
              slot_interval_d[i] = slot_interval_q[i+1];
              slot_preheat_d[i]  = slot_preheat_q[i+1];
              slot_prime_d[i]    = slot_prime_q[i+1];
            end
          end
          if (shift_vec[ENTRIES-1]) begin
            slot_id_d[ENTRIES-1]       = '0;
            slot_interval_d[ENTRIES-1] = '0;
            slot_preheat_d[ENTRIES-1]  = '0;
            slot_prime_d[ENTRIES-1]    = 1'b0;
          end
          occ_d     = occ_q - 1'b1;
          changes_d = changes_q + 1'b1;
          ok        = 1'b1;
        end
      end
      KIND_GET: begin
        rd_vec = hit_vec;
        ok     = any_hit;
      end
      KIND_AT: begin
        rd_vec = at_vec;
        ok     = |at_vec;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // read mux, select is one-hot or empty
  always_comb begin
    rd_id       = '0;
    rd_interval = '0;
    rd_preheat  = '0;
    rd_prime    = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      rd_id       = rd_id       | ({ID_BITS{rd_vec[i]}} & slot_id_q[i]);
      rd_interval = rd_interval | ({SECS_W{rd_vec[i]}} & slot_interval_q[i]);
      rd_preheat  = rd_preheat  | ({SECS_W{rd_vec[i]}} & slot_preheat_q[i]);
      rd_prime    = rd_prime    | (rd_vec[i] & slot_prime_q[i]);
    end
  end

  always_comb begin
    result_o.ok             = ok;
    result_o.found_id       = CID_W'(rd_id);
    result_o.found_interval = rd_interval;
    result_o.found_preheat  = rd_preheat;
    result_o.found_prime    = rd_prime;
    result_o.entry_count    = COUNT_W'(occ_d);
    result_o.change_count   = changes_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_id_q[i]       <= '0;
        slot_interval_q[i] <= '0;
        slot_preheat_q[i]  <= '0;
        slot_prime_q[i]    <= 1'b0;
      end
      occ_q     <= '0;
      changes_q <= '0;
    end else if (commit_i) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_id_q[i]       <= slot_id_d[i];
        slot_interval_q[i] <= slot_interval_d[i];
        slot_preheat_q[i]  <= slot_preheat_d[i];
        slot_prime_q[i]    <= slot_prime_d[i];
      end
      occ_q     <= occ_d;
      changes_q <= changes_d;
    end
  end

endmodule
